// ----- hw/rtl/cbsm_pkg.sv -----
// Shared types and constants for the counted-blink stall monitor.
`timescale 1ns / 1ps

package cbsm_pkg;

  // Register file geometry: five registers at word addresses
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_ON_TIME       = 3'd0,
    REG_BLINK_PERIOD  = 3'd1,
    REG_PAUSE_LENGTH  = 3'd2,
    REG_STALL_LIMIT   = 3'd3,
    REG_HEALTHY_STAGE = 3'd4
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [15:0] ON_TIME_RST       = 16'd250;
  localparam logic [15:0] BLINK_PERIOD_RST  = 16'd1000;
  localparam logic [15:0] PAUSE_LENGTH_RST  = 16'd3000;
  localparam logic [15:0] STALL_LIMIT_RST   = 16'd5000;
  localparam logic [7:0]  HEALTHY_STAGE_RST = 8'd11;

  // Blink phase after reset: first burst starts shortly after reset
  localparam logic [15:0] BLINK_PHASE_RST = 16'd2900;

  // Settings handed from the register file to the tick logic
  typedef struct packed {
    logic [15:0] on_time;
    logic [15:0] blink_period;
    logic [15:0] pause_length;
    logic [15:0] stall_limit;
    logic [7:0]  healthy_stage;
  } cfg_t;

endpackage

// ----- hw/rtl/cbsm_cfg.sv -----
// APB-style configuration register file of the stall monitor.
`timescale 1ns / 1ps

module cbsm_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cbsm_pkg::AddrW-1:0] cfg_paddr,
  input  logic [cbsm_pkg::DataW-1:0] cfg_pwdata,
  output logic [cbsm_pkg::DataW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output cbsm_pkg::cfg_t             cfg
);
  import cbsm_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[AddrW-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Write decode; addresses past the last register are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ON_TIME:       cfg_nxt.on_time       = cfg_pwdata[15:0];
        REG_BLINK_PERIOD:  cfg_nxt.blink_period  = cfg_pwdata[15:0];
        REG_PAUSE_LENGTH:  cfg_nxt.pause_length  = cfg_pwdata[15:0];
        REG_STALL_LIMIT:   cfg_nxt.stall_limit   = cfg_pwdata[15:0];
        REG_HEALTHY_STAGE: cfg_nxt.healthy_stage = cfg_pwdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_ON_TIME:       cfg_prdata = {16'd0, cfg_r.on_time};
      REG_BLINK_PERIOD:  cfg_prdata = {16'd0, cfg_r.blink_period};
      REG_PAUSE_LENGTH:  cfg_prdata = {16'd0, cfg_r.pause_length};
      REG_STALL_LIMIT:   cfg_prdata = {16'd0, cfg_r.stall_limit};
      REG_HEALTHY_STAGE: cfg_prdata = {24'd0, cfg_r.healthy_stage};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time       <= ON_TIME_RST;
      cfg_r.blink_period  <= BLINK_PERIOD_RST;
      cfg_r.pause_length  <= PAUSE_LENGTH_RST;
      cfg_r.stall_limit   <= STALL_LIMIT_RST;
      cfg_r.healthy_stage <= HEALTHY_STAGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hw/rtl/counted_blink_stall_monitor.sv -----
// Top level of the counted-blink stall monitor: tick state and result register.
`timescale 1ns / 1ps

// Each accepted request is one millisecond tick and yields exactly one result,
// presented on the out_ port in the cycle after acceptance. The tick logic is a
// single pass of counter compares between the incoming request and the result
// register, so a new tick is taken every clock; in_ready drops only while a
// result is held because out_ready is low. Stage changes, stall detection with
// a one-time dump request, and the counted-blink LED sequence all update in
// that same cycle. Configuration registers sit on the APB-style cfg_ port at
// byte addresses 0x00 (on_time), 0x04 (blink_period), 0x08 (pause_length),
// 0x0C (stall_limit) and 0x10 (healthy_stage); pready is always high.
module counted_blink_stall_monitor (
  input  logic                       clk,
  input  logic                       rst_n,
  // tick requests
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_stage,
  input  logic [31:0]                in_pc_word,
  input  logic [31:0]                in_lr_word,
  // results
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_tick_count,
  output logic                       out_stage_changed,
  output logic                       out_led_on,
  output logic                       out_dump_now,
  output logic [31:0]                out_dump_pc,
  output logic [31:0]                out_dump_lr,
  output logic [7:0]                 out_dump_stage,
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cbsm_pkg::AddrW-1:0] cfg_paddr,
  input  logic [cbsm_pkg::DataW-1:0] cfg_pwdata,
  output logic [cbsm_pkg::DataW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import cbsm_pkg::*;

  cfg_t cfg;

  cbsm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Tick state
  logic [31:0] ms_r,        ms_nxt;
  logic [7:0]  seen_r,      seen_nxt;
  logic [15:0] stall_r,     stall_nxt;
  logic        dump_done_r, dump_done_nxt;
  logic [15:0] phase_r,     phase_nxt;
  logic [7:0]  blinks_r,    blinks_nxt;
  logic        led_r,       led_nxt;

  // Result register
  logic        out_valid_r;
  logic [31:0] out_tick_r;
  logic        out_changed_r;
  logic        out_led_r;
  logic        out_dump_r;
  logic [31:0] out_pc_r;
  logic [31:0] out_lr_r;
  logic [7:0]  out_stage_r;

  logic        accept;
  logic        changed;
  logic        stalling;
  logic [15:0] stall_inc;
  logic [15:0] phase_inc;
  logic        fire;

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  // Stage change and stall detection
  assign changed   = in_stage != seen_r;
  assign stalling  = ~changed & ~dump_done_r & (in_stage != cfg.healthy_stage);
  assign stall_inc = stall_r + 16'd1;
  assign fire      = stalling & (stall_inc >= cfg.stall_limit);

  always_comb begin
    ms_nxt        = ms_r + 32'd1;
    seen_nxt      = in_stage;
    dump_done_nxt = dump_done_r | fire;
    if (changed) begin
      stall_nxt = '0;
    end else if (stalling) begin
      stall_nxt = stall_inc;
    end else begin
      stall_nxt = stall_r;
    end
  end

  // Counted-blink sequencer: burst of stage blinks, then a pause
  assign phase_inc = phase_r + 16'd1;

  always_comb begin
    phase_nxt  = phase_inc;
    blinks_nxt = blinks_r;
    led_nxt    = led_r;
    priority if (blinks_r == 8'd0) begin
      if (phase_inc >= cfg.pause_length) begin
        blinks_nxt = in_stage;
        phase_nxt  = '0;
      end
    end else if (phase_inc == 16'd1) begin
      led_nxt = 1'b1;
    end else if (phase_inc == cfg.on_time) begin
      led_nxt = 1'b0;
    end else if (phase_inc >= cfg.blink_period) begin
      phase_nxt  = '0;
      blinks_nxt = blinks_r - 8'd1;
    end else begin
      // between blink events only the phase moves
      led_nxt = led_r;
    end
  end

  // State registers advance once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r        <= '0;
      seen_r      <= '0;
      stall_r     <= '0;
      dump_done_r <= 1'b0;
      phase_r     <= BLINK_PHASE_RST;
      blinks_r    <= '0;
      led_r       <= 1'b0;
    end else if (accept) begin
      ms_r        <= ms_nxt;
      seen_r      <= seen_nxt;
      stall_r     <= stall_nxt;
      dump_done_r <= dump_done_nxt;
      phase_r     <= phase_nxt;
      blinks_r    <= blinks_nxt;
      led_r       <= led_nxt;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Result payload; dump fields read zero unless the dump fires
  always_ff @(posedge clk) begin
    if (accept) begin
      out_tick_r    <= ms_nxt;
      out_changed_r <= changed;
      out_led_r     <= led_nxt;
      out_dump_r    <= fire;
      out_pc_r      <= fire ? in_pc_word : 32'd0;
      out_lr_r      <= fire ? in_lr_word : 32'd0;
      out_stage_r   <= fire ? in_stage   : 8'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tick_count    = out_tick_r;
  assign out_stage_changed = out_changed_r;
  assign out_led_on        = out_led_r;
  assign out_dump_now      = out_dump_r;
  assign out_dump_pc       = out_pc_r;
  assign out_dump_lr       = out_lr_r;
  assign out_dump_stage    = out_stage_r;

  // Once the dump has fired it never fires again
  a_dump_once: assert property (@(posedge clk) disable iff (!rst_n)
    dump_done_r |-> !fire)
    else $error("stall dump fired twice");

  // A firing tick leaves the dump latched and shows up on the result
  a_dump_latch: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fire |=> dump_done_r && out_valid_r && out_dump_r)
    else $error("dump fire not latched");

  // Dump payload is zero whenever no dump is reported
  a_dump_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_dump_r |->
      out_pc_r == 32'd0 && out_lr_r == 32'd0 && out_stage_r == 8'd0)
    else $error("dump payload set without dump");

  // The reported tick count tracks the state counter
  a_tick_track: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tick_r == ms_r)
    else $error("tick count out of step");

  // Stall counter is cleared by a stage change
  a_stall_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && changed |=> stall_r == 16'd0)
    else $error("stall count not cleared on stage change");

endmodule

// ----- verif/counted_blink_stall_monitor_test.sv -----
// Self-checking testbench for the counted-blink stall monitor: ticks, dumps, LED bursts.
`timescale 1ns / 1ps

module counted_blink_stall_monitor_test;
  import cbsm_pkg::*;

  // One tick request and the result it should produce
  typedef struct {
    logic [7:0]  stage;
    logic [31:0] pc_word;
    logic [31:0] lr_word;
  } tick_req_t;

  typedef struct {
    logic [31:0] tick_count;
    logic        stage_changed;
    logic        led_on;
    logic        dump_now;
    logic [31:0] dump_pc;
    logic [31:0] dump_lr;
    logic [7:0]  dump_stage;
  } tick_result_t;

  typedef enum int {
    TRAFFIC_STEADY,
    TRAFFIC_SPARSE_SEND,
    TRAFFIC_SLOW_RECV,
    TRAFFIC_BOTH_IDLE
  } traffic_mode_t;

  localparam int RandPhases    = 8;
  localparam int TicksPerPhase = 128;
  localparam int HoldCycles    = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_stage = '0;
  logic [31:0]        in_pc_word = '0;
  logic [31:0]        in_lr_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        out_tick_count;
  logic               out_stage_changed;
  logic               out_led_on;
  logic               out_dump_now;
  logic [31:0]        out_dump_pc;
  logic [31:0]        out_dump_lr;
  logic [7:0]         out_dump_stage;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [AddrW-1:0]   cfg_paddr = '0;
  logic [DataW-1:0]   cfg_pwdata = '0;
  logic [DataW-1:0]   cfg_prdata;
  logic               cfg_pready;

  counted_blink_stall_monitor dut (.*);

  always #5 clk = ~clk;

  // Traffic knobs, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold = 1'b0;
  logic        hold_go = 1'b0;

  // Stimulus and scoreboard storage
  tick_req_t    pending_ticks[$];
  tick_result_t expected_ticks[$];
  int           ticks_outstanding = 0;
  int           mismatches = 0;
  int           ticks_sent = 0;
  int           results_checked = 0;
  int           lit_results = 0;
  int           dump_results = 0;
  int           change_results = 0;
  int           reg_writes = 0;

  // Predictor state: settings mirror and tick state
  cfg_t        model_cfg = '{ON_TIME_RST, BLINK_PERIOD_RST, PAUSE_LENGTH_RST,
                              STALL_LIMIT_RST, HEALTHY_STAGE_RST};
  logic [31:0] ms_total = '0;
  logic [7:0]  prev_stage = '0;
  logic [15:0] stall_ticks = '0;
  logic        dump_fired = 1'b0;
  logic [15:0] phase_ctr = BLINK_PHASE_RST;
  logic [7:0]  burst_left = '0;
  logic        led_lit = 1'b0;

  // Advance the predictor by one tick and return what the block should report
  function automatic tick_result_t predict_tick(tick_req_t req);
    tick_result_t r;
    r = '{default: '0};
    ms_total = ms_total + 32'd1;
    r.tick_count = ms_total;

    // stage tracking and stall detection
    if (req.stage != prev_stage) begin
      r.stage_changed = 1'b1;
      prev_stage = req.stage;
      stall_ticks = '0;
    end else if (!dump_fired && req.stage != model_cfg.healthy_stage) begin
      stall_ticks = stall_ticks + 16'd1;
      if (stall_ticks >= model_cfg.stall_limit) begin
        dump_fired = 1'b1;
        r.dump_now = 1'b1;
        r.dump_pc = req.pc_word;
        r.dump_lr = req.lr_word;
        r.dump_stage = req.stage;
      end
    end

    // counted-blink sequencer; first matching rule wins
    phase_ctr = phase_ctr + 16'd1;
    if (burst_left == 8'd0) begin
      if (phase_ctr >= model_cfg.pause_length) begin
        burst_left = req.stage;
        phase_ctr = '0;
      end
    end else if (phase_ctr == 16'd1) begin
      led_lit = 1'b1;
    end else if (phase_ctr == model_cfg.on_time) begin
      led_lit = 1'b0;
    end else if (phase_ctr >= model_cfg.blink_period) begin
      phase_ctr = '0;
      burst_left = burst_left - 8'd1;
    end
    r.led_on = led_lit;
    return r;
  endfunction

  task automatic queue_tick(logic [7:0] stage, logic [31:0] pc, logic [31:0] lr);
    pending_ticks.push_back('{stage, pc, lr});
    ticks_outstanding++;
  endtask

  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic set_traffic(traffic_mode_t mode);
    case (mode)
      TRAFFIC_STEADY: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      TRAFFIC_SPARSE_SEND: begin
        send_idle_pct = 64;
        recv_stall_pct = 0;
      end
      TRAFFIC_SLOW_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 64;
      end
      default: begin
        send_idle_pct = 23;
        recv_stall_pct = 23;
      end
    endcase
  endtask

  // Wait until every queued tick has produced its result
  task automatic wait_drained();
    while (ticks_outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write, mirrored into the predictor, then read back
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    logic [31:0] readback;
    readback = (idx == REG_HEALTHY_STAGE) ? {24'd0, val[7:0]} : {16'd0, val};
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= readback;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_ON_TIME:       model_cfg.on_time = val;
      REG_BLINK_PERIOD:  model_cfg.blink_period = val;
      REG_PAUSE_LENGTH:  model_cfg.pause_length = val;
      REG_STALL_LIMIT:   model_cfg.stall_limit = val;
      default:           model_cfg.healthy_stage = val[7:0];
    endcase
    reg_writes++;
    // read back through the same port
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    check_field(idx.name(), readback, cfg_prdata);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] on_t, logic [15:0] period, logic [15:0] pause,
                           logic [15:0] limit, logic [7:0] healthy);
    write_reg(REG_ON_TIME, on_t);
    write_reg(REG_BLINK_PERIOD, period);
    write_reg(REG_PAUSE_LENGTH, pause);
    write_reg(REG_STALL_LIMIT, limit);
    write_reg(REG_HEALTHY_STAGE, {8'd0, healthy});
  endtask

  // Request driver: predicts each tick as it is accepted
  always @(posedge clk) begin : drive_ticks
    tick_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_ticks.push_back(predict_tick('{in_stage, in_pc_word, in_lr_word}));
        ticks_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_ticks.pop_front();
          in_valid <= 1'b1;
          in_stage <= nxt.stage;
          in_pc_word <= nxt.pc_word;
          in_lr_word <= nxt.lr_word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver with random stalls and the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: compare against the oldest prediction
  always @(posedge clk) begin : watch_results
    tick_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result with no tick pending: tick_count 0x%0h", out_tick_count);
        mismatches++;
      end else begin
        exp_r = expected_ticks.pop_front();
        check_field("tick_count", exp_r.tick_count, out_tick_count);
        check_field("stage_changed", 32'(exp_r.stage_changed), 32'(out_stage_changed));
        check_field("led_on", 32'(exp_r.led_on), 32'(out_led_on));
        check_field("dump_now", 32'(exp_r.dump_now), 32'(out_dump_now));
        check_field("dump_pc", exp_r.dump_pc, out_dump_pc);
        check_field("dump_lr", exp_r.dump_lr, out_dump_lr);
        check_field("dump_stage", 32'(exp_r.dump_stage), 32'(out_dump_stage));
        results_checked++;
        lit_results += exp_r.led_on;
        dump_results += exp_r.dump_now;
        change_results += exp_r.stage_changed;
        ticks_outstanding--;
      end
    end
  end

  // Long receiver hold-off, counted here so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("counted_blink_stall_monitor regression: fail");
    $finish;
  end

  // Main sequence
  initial begin
    logic [7:0] stage_now;
    int unsigned pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, healthy stage, stall build-up under default settings
    queue_tick(8'd0, 32'h0000_0000, 32'h0000_0000);
    queue_tick(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_tick(8'd255, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_tick(8'd11, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_tick(8'd11, 32'h0000_0001, 32'h8000_0000);
    queue_tick(8'd11, 32'h8000_0000, 32'h0000_0001);
    queue_tick(8'd0, 32'h1234_5678, 32'h9ABC_DEF0);
    for (int i = 0; i < 9; i++) queue_tick(8'd7, $urandom(), $urandom());
    wait_drained();

    // Limit lowered below the running stall count: next stalled tick dumps, once
    write_reg(REG_STALL_LIMIT, 16'd3);
    queue_tick(8'd7, 32'h8000_1234, 32'h0000_ABCD);
    queue_tick(8'd7, 32'hDEAD_0001, 32'hDEAD_0002);
    queue_tick(8'd7, 32'hDEAD_0003, 32'hDEAD_0004);
    queue_tick(8'd6, 32'h0BAD_F00D, 32'hFEED_0000);
    queue_tick(8'd6, $urandom(), $urandom());
    queue_tick(8'd6, $urandom(), $urandom());
    wait_drained();

    // Random phases, each under its own settings and traffic pattern
    stage_now = 8'd6;
    for (int p = 0; p < RandPhases; p++) begin
      set_traffic(TRAFFIC_STEADY);
      if (p == 0) begin
        write_all(16'd1, 16'd2, 16'd1, 16'd1, 8'd0);
      end else if (p == 1) begin
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
      end else begin
        write_all(16'($urandom_range(1, 6)), 16'($urandom_range(2, 8)),
                  16'($urandom_range(1, 12)), 16'($urandom_range(1, 40)),
                  8'($urandom_range(0, 255)));
      end
      set_traffic(traffic_mode_t'(p % 4));

      // mostly runs of one stage, with random jumps and visits to the healthy stage
      for (int i = 0; i < TicksPerPhase; i++) begin
        pick = $urandom_range(99);
        if (pick < 22) begin
          stage_now = 8'($urandom());
        end else if (pick < 30) begin
          stage_now = model_cfg.healthy_stage;
        end else if (pick < 33) begin
          stage_now = 8'($urandom_range(0, 3));
        end
        queue_tick(stage_now, $urandom(), $urandom());
      end
      if (p == 4) hold_go = 1'b1;
      wait_drained();
    end

    if (expected_ticks.size() != 0) begin
      $error("%0d predicted results never arrived", expected_ticks.size());
      mismatches++;
    end
    $display("Ran %0d ticks through %0d register writes; %0d results checked.",
             ticks_sent, reg_writes, results_checked);
    $display("Seen: %0d stage changes, %0d lit-LED ticks, %0d stall dumps, %0d mismatches.",
             change_results, lit_results, dump_results, mismatches);
    if (mismatches == 0) begin
      $display("counted_blink_stall_monitor regression: pass");
    end else begin
      $display("counted_blink_stall_monitor regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/cbsm_pkg.sv
hw/rtl/cbsm_cfg.sv
hw/rtl/counted_blink_stall_monitor.sv
verif/counted_blink_stall_monitor_test.sv
